@@ rtl/signed_int_to_radix_text_macros.svh @@
// Assertion macros used by the radix text converter datapath.
`ifndef SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low.
`define SIRT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sirt assertion failed");

// Next-cycle implication, checked on i_clk, off while i_rst_n is low.
`define SIRT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sirt assertion failed");

`endif

@@ rtl/sirt_pkg.sv @@
// Shared types, constants and functions of the radix text converter.
package sirt_pkg;

    localparam int VALUE_W      = 32;
    localparam int CFG_W        = 64;
    localparam int LEN_W        = 5;
    localparam int SYM_W        = 8;
    localparam int NUM_SYMBOLS  = 16;
    localparam int SYM_IDX_W    = 4;
    localparam int MAX_DIGITS   = 32;
    localparam int PTR_W        = 5;
    localparam int CNT_W        = 6;
    localparam int DIV_STEPS    = 4;   // 8 quotient bits per cycle
    localparam int STEP_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_SYMBOLS_DEF = 16;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LEN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;        // take a new value
        logic div_step;    // one byte of long division
        logic digit_end;   // last byte of this digit: push remainder
        logic emit_sign;   // load '-' into output register
        logic emit_digit;  // pop one digit into output register
    } t_cmd;

    typedef struct packed {
        logic base_ok;
        logic neg;
        logic q_zero;      // quotient after this digit is zero
        logic cnt_full;    // this push fills the digit stack
        logic cnt_last;    // one digit left on the stack
        logic out_free;    // output register can take a word
    } t_stat;

    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [CFG_W-1:0]     lo,
        input logic [CFG_W-1:0]     hi,
        input logic [SYM_IDX_W-1:0] idx
    );
        logic [CFG_W-1:0] word;
        word = idx[SYM_IDX_W-1] ? hi : lo;
        return word[{idx[SYM_IDX_W-2:0], 3'b000} +: SYM_W];
    endfunction

    // Length range, sign symbols and pairwise check of the symbols in use; all compares run in parallel.
    function automatic logic base_valid(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [LEN_W-1:0] len,
        input logic [LEN_W-1:0] max_len
    );
        logic             ok;
        logic [SYM_W-1:0] a;
        ok = (len >= LEN_W'(2)) && (len <= max_len);
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
            a = symbol_at(lo, hi, SYM_IDX_W'(i));
            if (LEN_W'(i) < len) begin
                if (a == SYM_PLUS || a == SYM_MINUS) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
                    if (LEN_W'(j) < len && symbol_at(lo, hi, SYM_IDX_W'(j)) == a) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

@@ rtl/sirt_ctrl.sv @@
// Sequencer of the radix text converter: check, divide, emit.
module sirt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output sirt_pkg::t_cmd   o_cmd,
    input  sirt_pkg::t_stat  i_stat
);

    sirt_pkg::t_state r_state, n_state;
    logic [sirt_pkg::STEP_W-1:0] r_step, n_step;
    logic step_last;

    assign step_last = (r_step == sirt_pkg::STEP_W'(sirt_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sirt_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            sirt_pkg::ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = sirt_pkg::ST_CHECK;
                end
            end
            sirt_pkg::ST_CHECK: begin
                n_step  = '0;
                n_state = i_stat.base_ok ? sirt_pkg::ST_DIV : sirt_pkg::ST_IDLE;
            end
            sirt_pkg::ST_DIV: begin
                n_step = r_step + 1'b1;
                if (step_last && (i_stat.q_zero || i_stat.cnt_full)) begin
                    n_state = i_stat.neg ? sirt_pkg::ST_SIGN : sirt_pkg::ST_EMIT;
                end
            end
            sirt_pkg::ST_SIGN: begin
                if (i_stat.out_free) begin
                    n_state = sirt_pkg::ST_EMIT;
                end
            end
            sirt_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.cnt_last) begin
                    n_state = sirt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sirt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            sirt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sirt_pkg::ST_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.digit_end = step_last;
            end
            sirt_pkg::ST_SIGN: begin
                o_cmd.emit_sign = i_stat.out_free;
            end
            sirt_pkg::ST_EMIT: begin
                o_cmd.emit_digit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/sirt_dp.sv @@
// Datapath: config registers, byte-wise long division, digit stack, output register.
`include "signed_int_to_radix_text_macros.svh"

module sirt_dp #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sirt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [sirt_pkg::VALUE_W-1:0]   i_value,
    input  sirt_pkg::t_cmd                 i_cmd,
    output sirt_pkg::t_stat                o_stat,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [sirt_pkg::SYM_W-1:0]     o_out_byte,
    output logic                           o_out_last
);

    localparam int DIG_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;

    logic [sirt_pkg::CFG_W-1:0]   r_alpha_lo, r_alpha_hi;
    logic [sirt_pkg::LEN_W-1:0]   r_radix_len;
    logic                         r_base_ok;

    logic                         r_neg;
    logic [sirt_pkg::VALUE_W-1:0] r_work;
    logic [sirt_pkg::LEN_W-1:0]   r_rem;
    logic [sirt_pkg::CNT_W-1:0]   r_cnt;
    logic [DIG_W-1:0]             r_stack [sirt_pkg::MAX_DIGITS];

    logic                         r_out_valid;
    logic [sirt_pkg::SYM_W-1:0]   r_out_byte;
    logic                         r_out_last;

    logic [sirt_pkg::LEN_W-1:0]   rem_next;
    logic [7:0]                   q_byte;
    logic [sirt_pkg::VALUE_W-1:0] quo_next;
    logic [sirt_pkg::VALUE_W-1:0] mag_in;
    logic [sirt_pkg::PTR_W-1:0]   pop_ptr;
    logic [DIG_W-1:0]             pop_digit;
    logic                         out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lo  <= '0;
            r_alpha_hi  <= '0;
            r_radix_len <= '0;
            r_base_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sirt_pkg::CFG_ALPHA_LO:  r_alpha_lo  <= i_cfg_data;
                    sirt_pkg::CFG_ALPHA_HI:  r_alpha_hi  <= i_cfg_data;
                    sirt_pkg::CFG_RADIX_LEN: r_radix_len <= i_cfg_data[sirt_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            r_base_ok <= sirt_pkg::base_valid(r_alpha_lo, r_alpha_hi, r_radix_len,
                                              sirt_pkg::LEN_W'(MAX_SYMBOLS));
        end
    end

    // Eight restoring steps on the small remainder; rem stays below radix <= 16.
    always_comb begin
        rem_next = r_rem;
        q_byte   = '0;
        for (int b = 7; b >= 0; b--) begin
            rem_next = {rem_next[sirt_pkg::LEN_W-2:0], r_work[24 + b]};
            if (rem_next >= r_radix_len) begin
                rem_next  = rem_next - r_radix_len;
                q_byte[b] = 1'b1;
            end
        end
    end

    assign quo_next  = {r_work[23:0], q_byte};
    assign mag_in    = i_value[sirt_pkg::VALUE_W-1] ? (sirt_pkg::VALUE_W'(0) - i_value) : i_value;
    assign pop_ptr   = sirt_pkg::PTR_W'(r_cnt - 1'b1);
    assign pop_digit = r_stack[pop_ptr];
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.digit_end) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[sirt_pkg::VALUE_W-1];
            r_work <= mag_in;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= quo_next;
            r_rem  <= i_cmd.digit_end ? '0 : rem_next;
        end
        if (i_cmd.digit_end) begin
            r_stack[r_cnt[sirt_pkg::PTR_W-1:0]] <= rem_next[DIG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_byte <= sirt_pkg::SYM_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_byte <= sirt_pkg::symbol_at(r_alpha_lo, r_alpha_hi,
                                              sirt_pkg::SYM_IDX_W'(pop_digit));
            r_out_last <= (r_cnt == sirt_pkg::CNT_W'(1));
        end
    end

    assign o_stat.base_ok  = r_base_ok;
    assign o_stat.neg      = r_neg;
    assign o_stat.q_zero   = (quo_next == '0);
    assign o_stat.cnt_full = (r_cnt == sirt_pkg::CNT_W'(sirt_pkg::MAX_DIGITS - 1));
    assign o_stat.cnt_last = (r_cnt == sirt_pkg::CNT_W'(1));
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    `SIRT_ASSERT_NOW(a_pop_nonempty, i_cmd.emit_digit, r_cnt != '0)
    `SIRT_ASSERT_NOW(a_push_room, i_cmd.digit_end, r_cnt < sirt_pkg::CNT_W'(sirt_pkg::MAX_DIGITS))
    `SIRT_ASSERT_NOW(a_rem_below_radix, i_cmd.div_step, r_rem < r_radix_len)
    `SIRT_ASSERT_NOW(a_emit_into_free_slot, i_cmd.emit_sign || i_cmd.emit_digit, out_free)
    `SIRT_ASSERT_NEXT(a_last_digit_marked, i_cmd.emit_digit && r_cnt == sirt_pkg::CNT_W'(1),
                      r_out_valid && r_out_last)

endmodule

@@ rtl/signed_int_to_radix_text.sv @@
// Top level: signed 32-bit integer to text in a configurable radix.
//
//  port group      dir   payload (low bit up)
//  s_t*            in    tdata: value[31:0]
//  m_t*            out   tdata: text_byte[7:0]; tlast: final_char
//  i_cfg_*         in    idx 0 alphabet_low, 1 alphabet_high, 2 radix_len
//
// Each number is loaded and its base checked, then the byte-wise divider finds one digit
// after another (8 quotient bits per cycle), then the characters, a minus sign first if
// the value is negative, drain through the output register.
// Ready returns once the last character is in the output register.
// An invalid base ends the number after the check with no words out.
// A stalled m_tready holds the output word; reset is synchronous, active low.
module signed_int_to_radix_text #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sirt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic signed [31:0]             s_tdata,   // value[31:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // text_byte[7:0]
    output logic                           m_tlast    // final_char
);

    sirt_pkg::t_cmd  cmd;
    sirt_pkg::t_stat stat;

    sirt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    sirt_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_value     (s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_byte  (m_tdata),
        .o_out_last  (m_tlast)
    );

endmodule

@@ bench/signed_int_to_radix_text_tb.sv @@
// Testbench for signed_int_to_radix_text: predicted text checked word by word.
`timescale 1ns / 100ps

module signed_int_to_radix_text_tb;

    localparam int HALF_PERIOD = 5;
    localparam int SETTLE_CYCLES = 200;   // settle time after the last word, sized for the longest number
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_PHASES = 10;
    localparam logic [sirt_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [sirt_pkg::SYM_W-1:0] text_byte;
        logic                       final_char;
    } t_text_char;

    class t_radix_text_checker;
        logic [sirt_pkg::CFG_W-1:0] alpha_lo;
        logic [sirt_pkg::CFG_W-1:0] alpha_hi;
        logic [sirt_pkg::LEN_W-1:0] radix;
        t_text_char                 expected_text[$];
        int                         errors;

        function new();
            alpha_lo = '0;
            alpha_hi = '0;
            radix    = '0;
            errors   = 0;
        endfunction

        function void set_register(logic [sirt_pkg::CFG_IDX_W-1:0] idx,
                                   logic [sirt_pkg::CFG_W-1:0] data);
            case (idx)
                sirt_pkg::CFG_ALPHA_LO:  alpha_lo = data;
                sirt_pkg::CFG_ALPHA_HI:  alpha_hi = data;
                sirt_pkg::CFG_RADIX_LEN: radix = data[sirt_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [sirt_pkg::SYM_W-1:0] digit_symbol(int i);
            logic [sirt_pkg::CFG_W-1:0] w;
            w = (i < 8) ? alpha_lo : alpha_hi;
            return w[(i % 8) * 8 +: sirt_pkg::SYM_W];
        endfunction

        function bit radix_usable();
            logic [sirt_pkg::SYM_W-1:0] a;
            if (radix < 2 || radix > sirt_pkg::MAX_SYMBOLS_DEF) return 1'b0;
            for (int i = 0; i < radix; i++) begin
                a = digit_symbol(i);
                if (a == sirt_pkg::SYM_PLUS || a == sirt_pkg::SYM_MINUS) return 1'b0;
                for (int j = i + 1; j < radix; j++)
                    if (digit_symbol(j) == a) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Expected characters of one accepted number, most significant digit first.
        function void render_value(logic signed [sirt_pkg::VALUE_W-1:0] value);
            logic [sirt_pkg::VALUE_W-1:0] mag;
            logic [3:0]                   digits[sirt_pkg::MAX_DIGITS];
            int                           nd;
            t_text_char                   c;
            if (!radix_usable()) return;
            mag = value;
            if (value[sirt_pkg::VALUE_W-1]) mag = ~mag + 1'b1;   // most negative stays 2^31
            nd = 0;
            do begin
                digits[nd] = 4'(mag % radix);
                mag = mag / radix;
                nd++;
            end while (mag != 0 && nd < sirt_pkg::MAX_DIGITS);
            if (value[sirt_pkg::VALUE_W-1]) begin
                c.text_byte  = sirt_pkg::SYM_MINUS;
                c.final_char = 1'b0;
                expected_text.push_back(c);
            end
            for (int k = nd - 1; k >= 0; k--) begin
                c.text_byte  = digit_symbol(digits[k]);
                c.final_char = (k == 0);
                expected_text.push_back(c);
            end
        endfunction

        function void check_char(logic [sirt_pkg::SYM_W-1:0] text_byte, logic final_char);
            t_text_char want;
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected word text_byte=%02h final_char=%0b",
                         $time, text_byte, final_char);
                errors++;
                return;
            end
            want = expected_text.pop_front();
            if (want.text_byte !== text_byte) begin
                $display("%0t: text_byte mismatch expected=%02h actual=%02h",
                         $time, want.text_byte, text_byte);
                errors++;
            end
            if (want.final_char !== final_char) begin
                $display("%0t: final_char mismatch expected=%0b actual=%0b",
                         $time, want.final_char, final_char);
                errors++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [sirt_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [sirt_pkg::CFG_W-1:0]       i_cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic signed [31:0]               s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [7:0]                       m_tdata;
    logic                             m_tlast;

    t_radix_text_checker chk = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;

    signed_int_to_radix_text u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    int hold_seen = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            chk.check_char(m_tdata, m_tlast);
    end

    initial begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_value(input logic signed [31:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        chk.render_value(value);
    endtask

    task automatic write_reg(input logic [sirt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sirt_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        chk.set_register(idx, data);
    endtask

    task automatic load_alphabet(input logic [sirt_pkg::CFG_W-1:0] lo,
                                 input logic [sirt_pkg::CFG_W-1:0] hi,
                                 input logic [sirt_pkg::LEN_W-1:0] len);
        write_reg(sirt_pkg::CFG_ALPHA_LO, lo);
        write_reg(sirt_pkg::CFG_ALPHA_HI, hi);
        write_reg(sirt_pkg::CFG_RADIX_LEN, sirt_pkg::CFG_W'(len));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block is idle once every text word is out and a long number's worth has passed.
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Distinct symbols; optionally broken by a repeat, a sign symbol or a bad length.
    task automatic random_alphabet(input int len, input bit spoil);
        logic [sirt_pkg::SYM_W-1:0] syms[sirt_pkg::NUM_SYMBOLS];
        bit                         used[256];
        logic [sirt_pkg::CFG_W-1:0] lo;
        logic [sirt_pkg::CFG_W-1:0] hi;
        int                         b;
        int                         i;
        int                         j;
        for (i = 0; i < sirt_pkg::NUM_SYMBOLS; i++) begin
            do b = $urandom_range(255);
            while (used[b] || b == sirt_pkg::SYM_PLUS || b == sirt_pkg::SYM_MINUS);
            used[b] = 1'b1;
            syms[i] = sirt_pkg::SYM_W'(b);
        end
        // junk above the used range must be ignored
        if (len < sirt_pkg::NUM_SYMBOLS && $urandom_range(1))
            syms[$urandom_range(sirt_pkg::NUM_SYMBOLS - 1, len)] =
                $urandom_range(1) ? sirt_pkg::SYM_PLUS : syms[0];
        if (spoil) begin
            i = $urandom_range(len - 1);
            case ($urandom_range(3))
                0: begin
                    j = $urandom_range(len - 1);
                    if (j == i) j = (i + 1) % len;
                    syms[j] = syms[i];
                end
                1: syms[i] = sirt_pkg::SYM_PLUS;
                2: syms[i] = sirt_pkg::SYM_MINUS;
                default: len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(31, 17);
            endcase
        end
        for (i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = syms[i];
            hi[i*8 +: 8] = syms[i + 8];
        end
        load_alphabet(lo, hi, sirt_pkg::LEN_W'(len));
    endtask

    function automatic logic signed [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(600) - 300;
            2: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1)) v = ~v + 1'b1;
            end
            default: begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h1;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        int  n;
        int  len;
        bit  spoil;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset alphabet is empty: no text
        send_value(32'sd42);
        wait_idle();

        // decimal
        load_alphabet(64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938, 5'd10);
        send_value(0);
        send_value(7);
        send_value(-1);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(1000000000);
        wait_idle();

        // binary with byte 0 and byte FF as symbols; most negative gives 33 words
        load_alphabet(64'h0000_0000_0000_FF00, 64'h0, 5'd2);
        send_value(32'sh8000_0000);
        send_value(-1);
        send_value(32'sh7FFF_FFFF);
        send_value(5);
        wait_idle();

        // hex; unmapped index must leave the alphabet alone
        write_reg(CFG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
        load_alphabet(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 5'd16);
        send_value(32'shDEAD_BEEF);
        send_value(255);
        send_value(-256);
        wait_idle();

        // invalid bases: nothing comes out
        load_alphabet(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 5'd1);
        send_value(-9);
        wait_idle();
        load_alphabet(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 5'd17);
        send_value(9);
        wait_idle();
        load_alphabet(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 5'd31);
        send_value(-2);
        wait_idle();
        load_alphabet(64'h3736_3534_3332_312B, 64'h0000_0000_0000_3938, 5'd10);
        send_value(12);
        wait_idle();
        load_alphabet(64'h3736_3534_3332_3130, 64'h2D65_6463_6261_3938, 5'd16);
        send_value(-12);
        wait_idle();
        load_alphabet(64'h3736_3534_3332_3130, 64'h3065_6463_6261_3938, 5'd16);
        send_value(100);
        wait_idle();

        // sign symbols and repeats above the used range are fine
        load_alphabet(64'h3736_3534_2D2B_3130 | 64'h0000_0000_0000_0000, 64'h3030_3030_2B2D_2D2B,
                      5'd2);
        send_value(-5);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            spoil = (p == 4 || p == 7);
            len = (p == 0) ? 2 : (p == 1) ? sirt_pkg::NUM_SYMBOLS :
                  $urandom_range(sirt_pkg::NUM_SYMBOLS, 2);
            random_alphabet(len, spoil);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (p == 0) hold_asks++;   // long output stall: input must back up
            n = spoil ? 10 : 45;
            repeat (n) send_value(random_value());
            wait_idle();
        end

        if (chk.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
